[src/sfifo_pkg.sv]
// Package for the searchable FIFO with statistics.
// Holds opcode and status codes and the word types of both channels.
// No dependencies.
package sfifo_pkg;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_FIND    = 3'd2;
  localparam logic [2:0] OP_REPLACE = 3'd3;
  localparam logic [2:0] OP_STATS   = 3'd4;
  localparam logic [2:0] OP_LIST    = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        [2:0]  opcode;
    logic signed [31:0] value;
    logic signed [31:0] new_value;
  } sfifo_in_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] item;
    logic        [6:0]  position;
    logic signed [39:0] total;
    logic signed [31:0] minimum;
    logic signed [31:0] maximum;
    logic        [6:0]  fill;
    logic               last;
  } sfifo_out_t;

endpackage

[src/searchable_fifo_with_stats.sv]
// Searchable FIFO with statistics: ring of DEPTH signed words in one memory.
// Depends on sfifo_pkg; assertions attach from sfifo_checker.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   input   | in_valid  in_ready  in_data    | one request word (sfifo_in_t)
//   output  | out_valid out_ready out_data   | result words (sfifo_out_t)
//
// One request at a time; in_ready is high only while the sequencer is idle.
// Insert, or any request when empty, answers from idle; remove reads the head,
// find/replace walk to a match or the last entry, statistics and list walk all;
// the walk reads one memory entry a cycle while no word sits stalled in output.
// A result waits in the output register while the next request is accepted.
// Reset clears state, head, fill count and valids; the entry memory is not cleared.
module searchable_fifo_with_stats
  import sfifo_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sfifo_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sfifo_out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] HEAD_MAX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_EMIT} state_t;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    return s[AW-1:0];
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data_r;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      k_r, k_nxt;
  logic [2:0]         op_r, op_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] nval_r, nval_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic signed [31:0] min_r, min_nxt;
  logic signed [31:0] max_r, max_nxt;
  sfifo_out_t         res_r, res_nxt;
  logic               rd_vld_r;
  logic               out_valid_r;
  sfifo_out_t         out_data_r;

  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               emit_v;
  sfifo_out_t         emit_d;
  logic               consume;
  logic               out_free;
  logic               k_last;
  logic               first;
  logic signed [39:0] e_ext;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign k_last    = ((k_r + CW'(1)) == count_r);
  assign first     = (k_r == '0);
  assign e_ext     = {{8{rd_data_r[31]}}, rd_data_r};

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    nval_nxt  = nval_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = head_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    wr_data   = in_data.value;
    emit_v    = 1'b0;
    emit_d    = '0;
    consume   = 1'b0;
    in_ready  = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.opcode;
          key_nxt  = in_data.value;
          nval_nxt = in_data.new_value;
          k_nxt    = '0;
          case (in_data.opcode)
            OP_INSERT: begin
              emit_v      = 1'b1;
              emit_d.last = 1'b1;
              if (count_r == DEPTH_C) begin
                emit_d.status = ST_FULL;
              end else begin
                wr_en         = 1'b1;
                wr_addr       = slot_of(head_r, count_r[AW-1:0]);
                count_nxt     = count_r + CW'(1);
                emit_d.status = ST_OK;
              end
              emit_d.fill = 7'(count_nxt);
            end
            OP_REMOVE, OP_FIND, OP_REPLACE, OP_STATS, OP_LIST: begin
              if (count_r == '0) begin
                emit_v      = 1'b1;
                emit_d.last = 1'b1;
                if (in_data.opcode == OP_FIND || in_data.opcode == OP_REPLACE) begin
                  emit_d.status = ST_NOT_FOUND;
                end else begin
                  emit_d.status = ST_EMPTY;
                end
              end else begin
                // fetch the head entry and start the walk
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (rd_vld_r) begin
          emit_d.last = 1'b1;
          case (op_r)
            OP_REMOVE: begin
              consume       = 1'b1;
              emit_v        = 1'b1;
              emit_d.status = ST_OK;
              emit_d.item   = rd_data_r;
              head_nxt      = (head_r == HEAD_MAX) ? '0 : head_r + AW'(1);
              count_nxt     = count_r - CW'(1);
              emit_d.fill   = 7'(count_nxt);
            end
            OP_FIND, OP_REPLACE: begin
              consume     = 1'b1;
              emit_d.fill = 7'(count_r);
              if (rd_data_r == key_r) begin
                emit_v          = 1'b1;
                emit_d.status   = ST_OK;
                emit_d.position = 7'(k_r) + 7'd1;
                if (op_r == OP_REPLACE) begin
                  wr_en   = 1'b1;
                  wr_addr = slot_of(head_r, k_r[AW-1:0]);
                  wr_data = nval_r;
                end
              end else if (k_last) begin
                emit_v        = 1'b1;
                emit_d.status = ST_NOT_FOUND;
              end else begin
                k_nxt   = k_r + CW'(1);
                rd_en   = 1'b1;
                rd_addr = slot_of(head_r, k_nxt[AW-1:0]);
              end
            end
            OP_STATS: begin
              consume = 1'b1;
              sum_nxt = (first ? 40'sd0 : sum_r) + e_ext;
              min_nxt = (first || rd_data_r < min_r) ? rd_data_r : min_r;
              max_nxt = (first || rd_data_r > max_r) ? rd_data_r : max_r;
              if (k_last) begin
                emit_v         = 1'b1;
                emit_d.status  = ST_OK;
                emit_d.total   = sum_nxt;
                emit_d.minimum = min_nxt;
                emit_d.maximum = max_nxt;
                emit_d.fill    = 7'(count_r);
              end else begin
                k_nxt   = k_r + CW'(1);
                rd_en   = 1'b1;
                rd_addr = slot_of(head_r, k_nxt[AW-1:0]);
              end
            end
            OP_LIST: begin
              // hold the fetched entry until the output register frees up
              if (out_free) begin
                consume         = 1'b1;
                emit_v          = 1'b1;
                emit_d.status   = ST_OK;
                emit_d.item     = rd_data_r;
                emit_d.position = 7'(k_r) + 7'd1;
                emit_d.fill     = 7'(count_r);
                emit_d.last     = k_last;
                if (!k_last) begin
                  k_nxt   = k_r + CW'(1);
                  rd_en   = 1'b1;
                  rd_addr = slot_of(head_r, k_nxt[AW-1:0]);
                end
              end
            end
            default: begin
              consume   = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_EMIT: begin
        emit_v = 1'b1;
        emit_d = res_r;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (emit_v) begin
      if (out_free) begin
        state_nxt = emit_d.last ? S_IDLE : S_WALK;
      end else begin
        res_nxt   = emit_d;
        state_nxt = S_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_en ? 1'b1 : (consume ? 1'b0 : rd_vld_r);
      if (emit_v && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    k_r    <= k_nxt;
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    nval_r <= nval_nxt;
    sum_r  <= sum_nxt;
    min_r  <= min_nxt;
    max_r  <= max_nxt;
    res_r  <= res_nxt;
    if (emit_v && out_free) out_data_r <= emit_d;
  end

endmodule

[src/sfifo_checker.sv]
// Port-level checks for searchable_fifo_with_stats, bound to the top level.
// Depends on sfifo_pkg.
module sfifo_checker
  import sfifo_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input sfifo_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fill <= 7'(DEPTH))
    else $error("fill beyond depth");

  a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK && out_data.position != 7'd0)
    else $error("list word without ok status or position");

  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.position != 7'd0 |-> out_data.status == ST_OK &&
      out_data.position <= out_data.fill)
    else $error("position with bad status or beyond fill");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_FULL |-> out_data.fill == 7'(DEPTH))
    else $error("full reported below depth");

endmodule

bind searchable_fifo_with_stats sfifo_checker #(.DEPTH(DEPTH)) u_sfifo_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
